// ===== hw/rtl/iee_pkg.sv =====
// Package for the infix expression evaluator: widths, operator codes,
// status codes and the precedence relation. No dependencies.
`timescale 1ns / 1ps
package iee_pkg;

  localparam int OperatorDepth = 16;
  localparam int OperandDepth  = 16;
  localparam int FractionBits  = 16;
  localparam int ValueW        = 48;
  localparam int AccW          = 32;
  localparam int OprPtrW       = $clog2(OperatorDepth);
  localparam int OpdPtrW       = $clog2(OperandDepth);
  localparam int OprCntW       = $clog2(OperatorDepth + 1);
  localparam int OpdCntW       = $clog2(OperandDepth + 1);
  localparam int DivSteps      = ValueW + FractionBits;

  typedef enum logic [2:0] {
    OP_END   = 3'd0,
    OP_ADD   = 3'd1,
    OP_SUB   = 3'd2,
    OP_MUL   = 3'd3,
    OP_DIV   = 3'd4,
    OP_OPEN  = 3'd5,
    OP_CLOSE = 3'd6,
    OP_NONE  = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_PAREN    = 3'd1,
    ST_OPERAND  = 3'd2,
    ST_DIVZERO  = 3'd3,
    ST_OVERFLOW = 3'd4,
    ST_BADCHAR  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    REL_LESS    = 2'd0,
    REL_EQUAL   = 2'd1,
    REL_GREATER = 2'd2,
    REL_BAD     = 2'd3
  } rel_e;

  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChOpen  = 8'h28;
  localparam logic [7:0] ChClose = 8'h29;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  localparam logic [ValueW-1:0] PosMax = {1'b0, {(ValueW-1){1'b1}}};
  localparam logic [ValueW-1:0] NegMax = {1'b1, {(ValueW-1){1'b0}}};

  // Arithmetic unit command and result.
  typedef struct packed {
    logic              start;
    op_e               op;
    logic [ValueW-1:0] left;
    logic [ValueW-1:0] right;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [ValueW-1:0] result;
  } alu_rsp_t;

  function automatic op_e op_code(input logic [7:0] c);
    case (c)
      ChPlus:  op_code = OP_ADD;
      ChMinus: op_code = OP_SUB;
      ChStar:  op_code = OP_MUL;
      ChSlash: op_code = OP_DIV;
      ChOpen:  op_code = OP_OPEN;
      ChClose: op_code = OP_CLOSE;
      ChHash:  op_code = OP_END;
      default: op_code = OP_NONE;
    endcase
  endfunction

  function automatic rel_e relation(input op_e top, input op_e c);
    rel_e r;
    case (top)
      OP_ADD, OP_SUB:
        r = (c == OP_MUL || c == OP_DIV || c == OP_OPEN) ? REL_LESS : REL_GREATER;
      OP_MUL, OP_DIV:
        r = (c == OP_OPEN) ? REL_LESS : REL_GREATER;
      OP_OPEN:
        r = (c == OP_CLOSE) ? REL_EQUAL : ((c == OP_END) ? REL_BAD : REL_LESS);
      default:
        r = (c == OP_CLOSE) ? REL_BAD : ((c == OP_END) ? REL_EQUAL : REL_LESS);
    endcase
    relation = r;
  endfunction

  // Apply sign to a magnitude and clamp to the signed range.
  function automatic logic [ValueW-1:0] sat_mag(input logic neg,
                                                input logic [ValueW:0] mag);
    logic [ValueW-1:0] r;
    if (neg) begin
      if (mag > {1'b0, NegMax}) r = NegMax;
      else r = ValueW'(-mag);
    end else begin
      if (mag > {1'b0, PosMax}) r = PosMax;
      else r = mag[ValueW-1:0];
    end
    sat_mag = r;
  endfunction

endpackage

// ===== hw/rtl/infix_expression_evaluator.sv =====
// Infix expression evaluator top level: character parser, two stacks and
// the sequencer around the shared arithmetic unit.
// Depends on iee_pkg, iee_ram and iee_alu.
//
// Usage: one ASCII character per input item on char_code_i (valid/ready).
// Digits build a decimal number; + - * / ( ) are operators; # closes the
// expression and yields one result item (value_o in signed Q31.16 format
// with 16 fraction bits, status_o). Errors give value 0 with a nonzero
// status at once; later characters up to # are dropped without results.
// A digit is taken in the idle state and the next item may follow at once.
// An operator first pushes a pending number onto the operand stack; for
// each reduction it triggers, both operands are read and the arithmetic
// unit runs (48 steps of the serial multiplier for a multiply, 64 quotient
// bits for a divide). On # the result is read back through S_TOP and
// S_RD1; an error result goes through S_OUT. The block takes one item at a
// time: ready_o is low while an item is in work or a result waits.
// Reset empties both stacks (operator stack holds only the end marker)
// and clears the number. A stalled receiver holds the result in the
// output register, and no new item is accepted until it is taken.
`timescale 1ns / 1ps
module infix_expression_evaluator import iee_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [7:0]        char_code_i,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [ValueW-1:0] value_o,
  output logic [2:0]        status_o
);
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_PUSHN = 8'b0000_0010,
    S_TOP   = 8'b0000_0100,
    S_RD1   = 8'b0000_1000,
    S_RD2   = 8'b0001_0000,
    S_WAIT  = 8'b0010_0000,
    S_ALU   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_e;

  state_e              state_q, state_d;
  op_e                 opr_q [OperatorDepth];
  logic [OprCntW-1:0]  oprc_q, oprc_d;
  logic [OpdCntW-1:0]  opdc_q, opdc_d;
  logic [AccW-1:0]     acc_q, acc_d;
  logic                seen_q, seen_d;
  logic                disc_q, disc_d;
  op_e                 cur_q, cur_d;
  logic                end_q, end_d;
  logic [ValueW-1:0]   right_q, right_d;
  logic [ValueW-1:0]   left_q, left_d;
  logic [ValueW-1:0]   val_q, val_d;
  logic [2:0]          st_q, st_d;
  logic                ovalid_q, ovalid_d;

  logic                opr_we;
  logic                ram_we;
  logic [OpdPtrW-1:0]  ram_addr;
  logic [ValueW-1:0]   ram_wdata, ram_rdata;
  alu_req_t            alu_req;
  alu_rsp_t            alu_rsp;

  op_e                 top;
  rel_e                rel;
  logic [AccW+3:0]     acc_mul;
  logic [7:0]          dig;

  iee_ram #(.Width(ValueW), .Depth(OperandDepth)) u_opd_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  iee_alu u_alu (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  assign top = (oprc_q == '0) ? OP_END : opr_q[OprPtrW'(oprc_q - 1'b1)];
  assign rel = relation(top, cur_q);
  assign dig = char_code_i - ChZero;
  assign acc_mul = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0} + (AccW+4)'(dig[3:0]);

  always_comb begin
    state_d   = state_q;
    oprc_d    = oprc_q;
    opdc_d    = opdc_q;
    acc_d     = acc_q;
    seen_d    = seen_q;
    disc_d    = disc_q;
    cur_d     = cur_q;
    end_d     = end_q;
    right_d   = right_q;
    left_d    = left_q;
    val_d     = val_q;
    st_d      = st_q;
    ovalid_d  = ovalid_q;
    opr_we    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = OpdPtrW'(opdc_q);
    ram_wdata = '0;
    alu_req   = '0;
    alu_req.op    = top;
    alu_req.left  = left_q;
    alu_req.right = right_q;

    if (ovalid_q && ready_i) ovalid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (valid_i && !ovalid_q) begin
          cur_d = op_code(char_code_i);
          end_d = (char_code_i == ChHash);
          if (disc_q) begin
            if (char_code_i == ChHash) begin
              disc_d = 1'b0;
              oprc_d = OprCntW'(1);
              opdc_d = '0;
              acc_d  = '0;
              seen_d = 1'b0;
            end
          end else if (char_code_i >= ChZero && char_code_i <= ChNine) begin
            acc_d  = (acc_mul[AccW+3:AccW] != '0) ? '1 : acc_mul[AccW-1:0];
            seen_d = 1'b1;
          end else if (op_code(char_code_i) == OP_NONE) begin
            st_d = ST_BADCHAR;
            state_d = S_OUT;
          end else if (seen_q) begin
            state_d = S_PUSHN;
          end else begin
            state_d = S_TOP;
          end
        end
      end
      S_PUSHN: begin
        if (opdc_q >= OpdCntW'(OperandDepth)) begin
          st_d = ST_OVERFLOW;
          state_d = S_OUT;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = sat_mag(1'b0, (ValueW+1)'({acc_q, {FractionBits{1'b0}}}));
          opdc_d    = opdc_q + 1'b1;
          acc_d     = '0;
          seen_d    = 1'b0;
          state_d   = S_TOP;
        end
      end
      S_TOP: begin
        case (rel)
          REL_LESS: begin
            if (oprc_q >= OprCntW'(OperatorDepth)) begin
              st_d = ST_OVERFLOW;
              state_d = S_OUT;
            end else begin
              opr_we = 1'b1;
              oprc_d = oprc_q + 1'b1;
              state_d = S_IDLE;
            end
          end
          REL_BAD: begin
            st_d = ST_PAREN;
            state_d = S_OUT;
          end
          REL_EQUAL: begin
            if (top == OP_OPEN) begin
              oprc_d = oprc_q - 1'b1;
              state_d = S_IDLE;
            end else if (opdc_q != OpdCntW'(1)) begin
              st_d = ST_OPERAND;
              end_d = 1'b1;
              state_d = S_OUT;
            end else begin
              ram_addr = '0;
              state_d = S_RD1;
            end
          end
          default: begin
            if (opdc_q < OpdCntW'(2)) begin
              st_d = ST_OPERAND;
              state_d = S_OUT;
            end else begin
              ram_addr = OpdPtrW'(opdc_q - 1'b1);
              state_d = S_RD1;
            end
          end
        endcase
      end
      S_RD1: begin
        // result of the final read or right operand
        if (rel == REL_EQUAL) begin
          val_d = ram_rdata;
          st_d  = ST_OK;
          ovalid_d = 1'b1;
          oprc_d = OprCntW'(1);
          opdc_d = '0;
          acc_d  = '0;
          seen_d = 1'b0;
          state_d = S_IDLE;
        end else begin
          right_d = ram_rdata;
          ram_addr = OpdPtrW'(opdc_q - 2'd2);
          state_d = S_RD2;
        end
      end
      S_RD2: begin
        left_d = ram_rdata;
        if (top == OP_DIV && right_q == '0) begin
          st_d = ST_DIVZERO;
          state_d = S_OUT;
        end else begin
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        alu_req.start = 1'b1;
        state_d = S_ALU;
      end
      S_ALU: begin
        if (alu_rsp.done) begin
          ram_we    = 1'b1;
          ram_addr  = OpdPtrW'(opdc_q - 2'd2);
          ram_wdata = alu_rsp.result;
          oprc_d    = oprc_q - 1'b1;
          opdc_d    = opdc_q - 1'b1;
          state_d   = S_TOP;
        end
      end
      S_OUT: begin
        // error exit: clear stacks, emit status
        val_d    = '0;
        ovalid_d = 1'b1;
        disc_d   = !end_q;
        oprc_d   = OprCntW'(1);
        opdc_d   = '0;
        acc_d    = '0;
        seen_d   = 1'b0;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      oprc_q   <= OprCntW'(1);
      opdc_q   <= '0;
      acc_q    <= '0;
      seen_q   <= 1'b0;
      disc_q   <= 1'b0;
      ovalid_q <= 1'b0;
      for (int i = 0; i < OperatorDepth; i++) opr_q[i] <= OP_END;
    end else begin
      state_q  <= state_d;
      oprc_q   <= oprc_d;
      opdc_q   <= opdc_d;
      acc_q    <= acc_d;
      seen_q   <= seen_d;
      disc_q   <= disc_d;
      ovalid_q <= ovalid_d;
      if (opr_we) opr_q[OprPtrW'(oprc_q)] <= cur_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    end_q   <= end_d;
    right_q <= right_d;
    left_q  <= left_d;
    val_q   <= val_d;
    st_q    <= st_d;
  end

  assign ready_o  = (state_q == S_IDLE) && !ovalid_q;
  assign valid_o  = ovalid_q;
  assign value_o  = val_q;
  assign status_o = st_q;
endmodule

// ===== hw/rtl/iee_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module iee_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== hw/rtl/iee_alu.sv =====
// Shared arithmetic unit: saturating add/sub, shift-add multiply and
// restoring divide, one bit per cycle. Depends on iee_pkg.
`timescale 1ns / 1ps
module iee_alu import iee_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);
  localparam int CntW  = $clog2(DivSteps + 1);
  localparam int ProdW = 2 * ValueW;

  typedef enum logic [3:0] {
    A_IDLE = 4'b0001,
    A_MUL  = 4'b0010,
    A_DIV  = 4'b0100,
    A_DONE = 4'b1000
  } astate_e;

  astate_e             state_q, state_d;
  logic                neg_q, neg_d;
  logic [ValueW-1:0]   a_q, a_d;       // multiplier bits / dividend bits
  logic [ValueW-1:0]   b_q, b_d;       // magnitude of right operand
  logic [ProdW-1:0]    acc_q, acc_d;   // product
  logic [ValueW:0]     rem_q, rem_d;
  logic [ValueW:0]     quo_q, quo_d;
  logic                over_q, over_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [ValueW-1:0]   res_q, res_d;

  logic [ValueW-1:0]   mag_l, mag_r;
  logic [ValueW:0]     sum;
  logic [ValueW:0]     rem_sh;
  logic [ValueW:0]     quo_sh;
  logic                nbit;
  logic [ProdW-1:0]    prod_sh;

  assign mag_l = req_i.left[ValueW-1]  ? ValueW'(-req_i.left)  : req_i.left;
  assign mag_r = req_i.right[ValueW-1] ? ValueW'(-req_i.right) : req_i.right;

  always_comb begin
    state_d = state_q;
    neg_d   = neg_q;
    a_d     = a_q;
    b_d     = b_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    over_d  = over_q;
    cnt_d   = cnt_q;
    res_d   = res_q;
    sum     = '0;
    nbit    = 1'b0;
    rem_sh  = '0;
    quo_sh  = '0;
    prod_sh = '0;
    case (state_q)
      A_IDLE: begin
        if (req_i.start) begin
          neg_d  = req_i.left[ValueW-1] ^ req_i.right[ValueW-1];
          a_d    = mag_l;
          b_d    = mag_r;
          acc_d  = '0;
          rem_d  = '0;
          quo_d  = '0;
          over_d = 1'b0;
          cnt_d  = '0;
          case (req_i.op)
            OP_ADD, OP_SUB: begin
              if (req_i.op == OP_ADD)
                sum = {req_i.left[ValueW-1], req_i.left} + {req_i.right[ValueW-1], req_i.right};
              else
                sum = {req_i.left[ValueW-1], req_i.left} - {req_i.right[ValueW-1], req_i.right};
              // clamp on sign disagreement of the 49-bit sum
              if (sum[ValueW] != sum[ValueW-1])
                res_d = sum[ValueW] ? NegMax : PosMax;
              else
                res_d = sum[ValueW-1:0];
              state_d = A_DONE;
            end
            OP_MUL:  state_d = A_MUL;
            default: state_d = A_DIV;
          endcase
        end
      end
      A_MUL: begin
        // MSB-first shift-add
        prod_sh = {acc_q[ProdW-2:0], 1'b0};
        acc_d = a_q[ValueW-1] ? prod_sh + ProdW'(b_q) : prod_sh;
        a_d   = {a_q[ValueW-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(ValueW - 1)) begin
          res_d = sat_mag(neg_q, (acc_d >> FractionBits) > ProdW'({1'b0, NegMax})
                         ? {1'b1, {ValueW{1'b0}}}
                         : ValueW'(acc_d >> FractionBits) + (ValueW+1)'(0));
          state_d = A_DONE;
        end
      end
      A_DIV: begin
        // dividend is a << FractionBits; feed a's bits then zeros
        nbit   = a_q[ValueW-1];
        rem_sh = {rem_q[ValueW-1:0], nbit};
        a_d    = {a_q[ValueW-2:0], 1'b0};
        if (rem_sh >= {1'b0, b_q}) begin
          rem_d = rem_sh - {1'b0, b_q};
          quo_sh = {quo_q[ValueW-1:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          quo_sh = {quo_q[ValueW-1:0], 1'b0};
        end
        if (!over_q) begin
          quo_d = quo_sh;
          if (quo_sh > {1'b0, NegMax} || quo_q[ValueW]) over_d = 1'b1;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(DivSteps - 1)) begin
          res_d = sat_mag(neg_q, over_d ? {1'b1, {ValueW{1'b0}}} : quo_d);
          state_d = A_DONE;
        end
      end
      A_DONE: state_d = A_IDLE;
      default: state_d = A_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    a_q    <= a_d;
    b_q    <= b_d;
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    over_q <= over_d;
    cnt_q  <= cnt_d;
    res_q  <= res_d;
  end

  assign rsp_o.done   = (state_q == A_DONE);
  assign rsp_o.result = res_q;
endmodule

// ===== hw/rtl/iee_checker.sv =====
// Port-level checker for the infix expression evaluator, bound to the top.
// Depends on iee_pkg.
`timescale 1ns / 1ps
module iee_checker import iee_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              ready_o,
  input logic              valid_o,
  input logic              ready_i,
  input logic [ValueW-1:0] value_o,
  input logic [2:0]        status_o
);
  // Not ready while a result waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni) valid_o |-> !ready_o)
    else $error("ready while result pending");
  // Error results carry value zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o != 3'(ST_OK) |-> value_o == '0)
    else $error("error result with nonzero value");
  // Status is in range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> status_o <= 3'(ST_BADCHAR))
    else $error("status out of range");
  // Result holds while stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(value_o) && $stable(status_o))
    else $error("result dropped under stall");
endmodule

bind infix_expression_evaluator iee_checker u_iee_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .ready_o (ready_o),
  .valid_o (valid_o),
  .ready_i (ready_i),
  .value_o (value_o),
  .status_o(status_o)
);
